// ----- rtl/md_pkg.sv -----
// shared types and constants of the minkowski distance engine
`default_nettype none

package md_pkg;

   // result and accumulator widths
   localparam int OUT_BITS   = 26;
   localparam int SUM_BITS   = 43;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   // order register
   localparam int ORDER_BITS = 3;
   localparam logic [ORDER_BITS-1:0] ORDER_RESET = 3'd2;
   localparam logic [ORDER_BITS-1:0] ORDER_MIN   = 3'd1;
   localparam logic [ORDER_BITS-1:0] ORDER_MAX   = 3'd4;

   // job queue between accumulator and root unit
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = 2;
   localparam int QCNT_BITS = 3;

   // one finished vector waiting for its root
   typedef struct packed {
      logic [SUM_BITS-1:0]   sum;
      logic                  sat;
      logic [ORDER_BITS-1:0] order;
   } job_type;

   // queue head as seen by the root unit
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   typedef enum logic [2:0] {
      ROOT_IDLE,
      ROOT_START,
      ROOT_MUL,
      ROOT_ADD,
      ROOT_CMP
   } root_state_type;

endpackage

`default_nettype wire

// ----- rtl/md_front.sv -----
// front end: order register, |a-b|^k pipeline, saturating accumulator, queue credits
`default_nettype none

module md_front #(
   parameter int MAX_LEN    = 1024,
   parameter int COORD_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [COORD_BITS-1:0]                req_coord_a,
   input  wire logic [COORD_BITS-1:0]                req_coord_b,
   input  wire logic                                 req_last,
   input  wire logic                                 csr_we,
   input  wire logic [md_pkg::ORDER_BITS-1:0]        csr_wdata,
   input  wire logic                                 pop,
   output logic                                      push,
   output md_pkg::job_type                           push_job
);

   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int TERM_W = 4 * COORD_BITS;
   localparam int ADD_W  = ((TERM_W > md_pkg::SUM_BITS) ? TERM_W : md_pkg::SUM_BITS) + 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);

   logic [md_pkg::ORDER_BITS-1:0] order_ff, order_in;
   logic [md_pkg::QCNT_BITS-1:0]  credit_ff, credit_in;
   logic                          accept;
   logic [md_pkg::ORDER_BITS-1:0] eff_order;

   // pipeline valid / last
   logic v1_ff, v2_ff, v3_ff;
   logic l1_ff, l2_ff, l3_ff;
   logic [md_pkg::ORDER_BITS-1:0] k1_ff, k2_ff, k3_ff;
   logic [COORD_BITS-1:0] d1_ff, d2_ff;
   logic [SQ_W-1:0]       sq2_ff;
   logic [TERM_W-1:0]     term3_ff, term_in;

   // accumulator
   logic [md_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ov_ff, ov_in;
   logic [ADD_W-1:0]            wide_sum;
   logic [md_pkg::SUM_BITS-1:0] sum_new;
   logic                        ov_new;

   assign busy   = (credit_ff == '0);
   assign accept = start && !busy;

   // order out of range clamps to 1..4
   always_comb begin
      if (order_ff < md_pkg::ORDER_MIN) begin
         eff_order = md_pkg::ORDER_MIN;
      end else if (order_ff > md_pkg::ORDER_MAX) begin
         eff_order = md_pkg::ORDER_MAX;
      end else begin
         eff_order = order_ff;
      end
   end

   always_comb begin
      order_in = csr_we ? csr_wdata : order_ff;
      credit_in = credit_ff - md_pkg::QCNT_BITS'(accept && req_last)
                  + md_pkg::QCNT_BITS'(pop);
   end

   // power term from the difference and its square
   always_comb begin
      case (k2_ff)
         3'd1:    term_in = TERM_W'(d2_ff);
         3'd2:    term_in = TERM_W'(sq2_ff);
         3'd3:    term_in = TERM_W'(sq2_ff * TERM_W'(d2_ff));
         default: term_in = TERM_W'(sq2_ff) * TERM_W'(sq2_ff);
      endcase
   end

   // saturating accumulate, pair limit
   always_comb begin
      wide_sum = ADD_W'(sum_ff) + ADD_W'(term3_ff);
      if (count_ff >= CNT_W'(MAX_LEN)) begin
         sum_new  = md_pkg::SUM_MAX;
         ov_new   = 1'b1;
         count_in = count_ff;
      end else begin
         count_in = count_ff + CNT_W'(1);
         if (wide_sum > ADD_W'(md_pkg::SUM_MAX)) begin
            sum_new = md_pkg::SUM_MAX;
            ov_new  = 1'b1;
         end else begin
            sum_new = wide_sum[md_pkg::SUM_BITS-1:0];
            ov_new  = ov_ff;
         end
      end
      push           = 1'b0;
      push_job.sum   = sum_new;
      push_job.sat   = ov_new;
      push_job.order = k3_ff;
      sum_in         = sum_ff;
      ov_in          = ov_ff;
      if (v3_ff) begin
         if (l3_ff) begin
            push     = 1'b1;
            sum_in   = '0;
            ov_in    = 1'b0;
            count_in = '0;
         end else begin
            sum_in = sum_new;
            ov_in  = ov_new;
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= md_pkg::ORDER_RESET;
         credit_ff <= md_pkg::QCNT_BITS'(md_pkg::QDEPTH);
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         sum_ff    <= '0;
         count_ff  <= '0;
         ov_ff     <= 1'b0;
      end else begin
         order_ff  <= order_in;
         credit_ff <= credit_in;
         v1_ff     <= accept;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         ov_ff     <= ov_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      d1_ff    <= (req_coord_a >= req_coord_b) ? (req_coord_a - req_coord_b)
                                                : (req_coord_b - req_coord_a);
      l1_ff    <= req_last;
      k1_ff    <= eff_order;
      d2_ff    <= d1_ff;
      sq2_ff   <= SQ_W'(d1_ff) * SQ_W'(d1_ff);
      l2_ff    <= l1_ff;
      k2_ff    <= k1_ff;
      term3_ff <= term_in;
      l3_ff    <= l2_ff;
      k3_ff    <= k2_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/md_queue.sv -----
// small job queue between accumulator and root unit
`default_nettype none

module md_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire md_pkg::job_type push_job,
   input  wire logic           pop,
   output md_pkg::queue_head_type head
);

   md_pkg::job_type entries_ff [md_pkg::QDEPTH];
   logic [md_pkg::QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [md_pkg::QCNT_BITS-1:0] count_ff;

   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + md_pkg::QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + md_pkg::QPTR_BITS'(1);
         end
         count_ff <= count_ff + md_pkg::QCNT_BITS'(push) - md_pkg::QCNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/md_root.sv -----
// back end: bit-by-bit k-th root with a shared 26x26 multiplier
`default_nettype none

module md_root #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire md_pkg::queue_head_type        head,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [md_pkg::OUT_BITS-1:0]        rsp_distance_q8,
   output logic                               rsp_saturated
);

   localparam int OB    = md_pkg::OUT_BITS;
   localparam int PW    = 4 * OB;
   localparam int PPW   = 2 * OB;
   localparam int TW    = md_pkg::SUM_BITS + 4 * FRAC_BITS;
   localparam int CMPW  = (PW > TW) ? PW : TW;
   localparam int BIT_W = $clog2(OB);

   md_pkg::root_state_type state_ff, state_in;

   logic [TW-1:0]                 target_ff, target_in;
   logic [md_pkg::ORDER_BITS-1:0] order_ff, order_in;
   logic                          sat_ff, sat_in;
   logic [OB-1:0]                 r_ff, r_in;
   logic [OB-1:0]                 cand_ff, cand_in;
   logic [BIT_W-1:0]              bit_ff, bit_in;
   logic [PW-1:0]                 prev_ff, prev_in;
   logic [PW-1:0]                 acc_ff, acc_in;
   logic [PW-1:0]                 acc_sum;
   logic [PPW-1:0]                pp_ff, pp_in;
   logic [md_pkg::ORDER_BITS-1:0] pow_ff, pow_in;
   logic [1:0]                    chunk_ff, chunk_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0]                 dist_ff, dist_in;
   logic                          rsat_ff, rsat_in;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_q8 = dist_ff;
   assign rsp_saturated   = rsat_ff;

   assign acc_sum = acc_ff + (PW'(pp_ff) << (chunk_ff * OB));

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      order_in     = order_ff;
      sat_in       = sat_ff;
      r_in         = r_ff;
      cand_in      = cand_ff;
      bit_in       = bit_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      pp_in        = pp_ff;
      pow_in       = pow_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = 1'b0;
      dist_in      = dist_ff;
      rsat_in      = rsat_ff;
      pop          = 1'b0;
      unique case (state_ff)
         md_pkg::ROOT_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               order_in = head.job.order;
               sat_in   = head.job.sat;
               r_in     = '0;
               bit_in   = BIT_W'(OB - 1);
               case (head.job.order)
                  3'd1:    target_in = TW'(head.job.sum) << FRAC_BITS;
                  3'd2:    target_in = TW'(head.job.sum) << (2 * FRAC_BITS);
                  3'd3:    target_in = TW'(head.job.sum) << (3 * FRAC_BITS);
                  default: target_in = TW'(head.job.sum) << (4 * FRAC_BITS);
               endcase
               state_in = md_pkg::ROOT_START;
            end
         end
         md_pkg::ROOT_START: begin
            cand_in  = r_ff | (OB'(1) << bit_ff);
            prev_in  = PW'(cand_in);
            acc_in   = '0;
            pow_in   = 3'd1;
            chunk_in = 2'd0;
            state_in = (order_ff == md_pkg::ORDER_MIN) ? md_pkg::ROOT_CMP
                                                       : md_pkg::ROOT_MUL;
         end
         md_pkg::ROOT_MUL: begin
            pp_in    = PPW'(prev_ff[chunk_ff * OB +: OB]) * PPW'(cand_ff);
            state_in = md_pkg::ROOT_ADD;
         end
         md_pkg::ROOT_ADD: begin
            if (3'(chunk_ff) == pow_ff - 3'd1) begin
               // one more power of cand is complete
               prev_in  = acc_sum;
               acc_in   = '0;
               chunk_in = 2'd0;
               pow_in   = pow_ff + 3'd1;
               state_in = (pow_ff + 3'd1 == order_ff) ? md_pkg::ROOT_CMP
                                                      : md_pkg::ROOT_MUL;
            end else begin
               acc_in   = acc_sum;
               chunk_in = chunk_ff + 2'd1;
               state_in = md_pkg::ROOT_MUL;
            end
         end
         md_pkg::ROOT_CMP: begin
            if (CMPW'(prev_ff) <= CMPW'(target_ff)) begin
               r_in = cand_ff;
            end
            if (bit_ff == '0) begin
               rsp_valid_in = 1'b1;
               dist_in      = r_in;
               rsat_in      = sat_ff;
               state_in     = md_pkg::ROOT_IDLE;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = md_pkg::ROOT_START;
            end
         end
         default: begin
            state_in = md_pkg::ROOT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md_pkg::ROOT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      order_ff  <= order_in;
      sat_ff    <= sat_in;
      r_ff      <= r_in;
      cand_ff   <= cand_in;
      bit_ff    <= bit_in;
      prev_ff   <= prev_in;
      acc_ff    <= acc_in;
      pp_ff     <= pp_in;
      pow_ff    <= pow_in;
      chunk_ff  <= chunk_in;
      dist_ff   <= dist_in;
      rsat_ff   <= rsat_in;
   end

endmodule

`default_nettype wire

// ----- rtl/minkowski_distance.sv -----
// top level of the minkowski (lp) distance engine
//
// channel   ports                                  handshake
// -------   -------------------------------------  --------------------------------
// request   req_coord_a, req_coord_b, req_last     start high and busy low at edge
// response  rsp_distance_q8, rsp_saturated         rsp_valid one-cycle strobe
// config    csr_wdata (order, 1..4)                csr_we high at edge
//
// a coordinate pair is taken every cycle while busy is low; |a-b|^k is formed
// in three pipeline stages and summed in the fourth
// the root unit handles one vector at a time, one result bit per pass, at a
// pace set by its single shared multiplier
// a four-entry job queue holds finished sums; busy rises only when four
// vectors are pending a root, and drops as the root unit takes one
// reset is synchronous and clears the pipeline, the queue and the sums;
// order returns to 2
// the response side cannot stall: each result shows for exactly one cycle
`default_nettype none

module minkowski_distance #(
   parameter int MAX_LEN    = 1024,
   parameter int COORD_BITS = 8,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request transaction
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [COORD_BITS-1:0]           req_coord_a,
   input  wire logic [COORD_BITS-1:0]           req_coord_b,
   input  wire logic                            req_last,
   // response transaction
   output logic                                 rsp_valid,
   output logic [md_pkg::OUT_BITS-1:0]          rsp_distance_q8,
   output logic                                 rsp_saturated,
   // order register
   input  wire logic                            csr_we,
   input  wire logic [md_pkg::ORDER_BITS-1:0]   csr_wdata
);

   // accumulator to queue
   logic            push;
   md_pkg::job_type push_job;

   // queue to root unit, with the pop that also returns a credit to the front
   md_pkg::queue_head_type head;
   logic                   pop;

   // front end: raises each pair's difference to the k-th power, keeps per-vector sums, grants credits
   md_front #(
      .MAX_LEN    (MAX_LEN),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_coord_a (req_coord_a),
      .req_coord_b (req_coord_b),
      .req_last    (req_last),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .pop         (pop),
      .push        (push),
      .push_job    (push_job)
   );

   // decouples the pair stream from the slow root iteration
   md_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head)
   );

   // back end: exact floor of the k-th root, one result bit per pass
   md_root #(
      .FRAC_BITS (FRAC_BITS)
   ) u_root (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_distance_q8 (rsp_distance_q8),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

`default_nettype wire
